@@ sv/qsst_pkg.sv @@
// Shared types, constants and arithmetic helpers of the quadric side test.
package qsst_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QW = 64;
	localparam int CW = 32;
	localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		SURF_NONE   = 4'd0,
		SURF_PLANEX = 4'd1,
		SURF_PLANEY = 4'd2,
		SURF_PLANEZ = 4'd3,
		SURF_PLANE  = 4'd4,
		SURF_SPHERE = 4'd5,
		SURF_ELL    = 4'd6,
		SURF_CYLZ   = 4'd7,
		SURF_ELLZ   = 4'd8,
		SURF_CONE   = 4'd9
	} surf_t;

	typedef enum logic [1:0] {
		BAND_OUT,
		BAND_IN,
		BAND_MID
	} band_t;

	typedef struct packed {
		logic axis;
		logic plane;
		logic sphere;
		logic cyl;
		logic ell3;
		logic ell2;
		logic cone;
		logic bad;
	} cls_t;

	typedef struct packed {
		logic valid;
		logic res;
		logic bad;
		logic ell;
	} early_t;

	typedef struct packed {
		logic       ell3;
		logic [2:0] cneg;
		logic [2:0] cz;
		logic [2:0] pz;
		logic [2:0] pneg;
	} dside_t;

	typedef struct packed {
		logic [2:0]       vneg;
		logic [2:0][31:0] vm;
	} vside_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		return m;
	endfunction

	function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
		logic signed [63:0] s;
		s = $signed({{32{v[31]}}, v});
		return s;
	endfunction

	function automatic logic signed [63:0] sgn64(input logic neg, input logic [63:0] m);
		logic signed [63:0] s;
		s = $signed(m);
		return neg ? -s : s;
	endfunction

	// Saturating add; operands never reach the most negative code.
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [64:0] smax;
		logic signed [63:0] r;
		smax = $signed({1'b0, QMAX});
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > smax) begin
			r = QMAX;
		end else if (s < -smax) begin
			r = -QMAX;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	function automatic band_t band(input logic signed [63:0] d, input logic [30:0] tol);
		logic signed [63:0] t;
		band_t b;
		t = $signed({33'b0, tol});
		if (d > t) begin
			b = BAND_OUT;
		end else if (d < -t) begin
			b = BAND_IN;
		end else begin
			b = BAND_MID;
		end
		return b;
	endfunction

endpackage

@@ sv/qsst_dly.sv @@
// Fixed-length delay line for side information that travels beside a long pipeline.
module qsst_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				tap_s[k] <= '0;
			end
		end else begin
			tap_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

@@ sv/qsst_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module qsst_div #(
	parameter int NUM_W = qsst_pkg::QW,
	parameter int DEN_W = qsst_pkg::CW
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W-1];
	logic [NUM_W-1:0] num_s [NUM_W-1];
	logic [DEN_W-1:0] den_s [NUM_W-1];
	logic [NUM_W-1:0] quo_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [NUM_W-1:0] num_in;
		logic [NUM_W-1:0] quo_in;
		logic [DEN_W:0]   trial;
		logic             fits;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = den;
			assign num_in = num;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {rem_in, num_in[NUM_W-1]};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			quo_s[k] <= {quo_in[NUM_W-2:0], fits};
		end

		if (k < NUM_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				num_s[k] <= {num_in[NUM_W-2:0], 1'b0};
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[NUM_W-1];

endmodule

@@ sv/qsst_mulsh.sv @@
// Three-stage 64x32 magnitude multiply, scaled down by the fraction bits and saturated.
module qsst_mulsh #(
	parameter int FRAC_BITS = qsst_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic [63:0]        a,
	input  logic [31:0]        b,
	input  logic               neg,
	output logic signed [63:0] y
);

	logic [63:0]        plo_s1;
	logic [63:0]        phi_s1;
	logic               neg_s1;
	logic [95:0]        sum_s2;
	logic               neg_s2;
	logic [95:0]        sh;
	logic [63:0]        mag;
	logic signed [63:0] y_s3;

	always_ff @(posedge clk) begin
		plo_s1 <= 64'(a[31:0]) * 64'(b);
		phi_s1 <= 64'(a[63:32]) * 64'(b);
		neg_s1 <= neg;
		sum_s2 <= {phi_s1, 32'b0} + {32'b0, plo_s1};
		neg_s2 <= neg_s1;
		y_s3   <= qsst_pkg::sgn64(neg_s2, mag);
	end

	always_comb begin
		sh  = sum_s2 >> FRAC_BITS;
		mag = (|sh[95:63]) ? 64'(qsst_pkg::QMAX) : {1'b0, sh[62:0]};
	end

	assign y = y_s3;

endmodule

@@ sv/quadric_surface_side_test_core.sv @@
// Top level of the quadric surface side test pipeline.
//
//  channel   ports                                   transaction
//  ------    -----                                   -----------
//  item in   start, busy, surf_type, coef*, pos_*,   start & !busy at clk edge
//            dir_*
//  config    cfg_valid, cfg_ready, cfg_data          cfg_valid & cfg_ready
//  result    done, inside_res, bad_type              done high for one cycle
//
// One item is taken every cycle; busy is never raised. The result of an item
// shows on done after a delay set mostly by the one-bit-per-stage divider
// used by the ellipsoid types.
// Reset clears the valid bits and sets the tolerance to one LSB.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module quadric_surface_side_test_core #(
	parameter int FRAC_BITS = qsst_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  surf_type,
	input  logic signed [31:0] coef0,
	input  logic signed [31:0] coef1,
	input  logic signed [31:0] coef2,
	input  logic signed [31:0] coef3,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,
	output logic        done,
	output logic        inside_res,
	output logic        bad_type
);

	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

	logic [30:0] tol_q;

	// Stage 1: captured item.
	logic              valid_s1;
	logic [3:0]        type_s1;
	logic signed [31:0] c_s1 [4];
	logic signed [31:0] p_s1 [3];
	logic signed [31:0] v_s1 [3];

	// Stage 2: magnitudes, signs and operand selection.
	qsst_pkg::cls_t    cls_d;
	logic [1:0]        sel_d;
	logic              valid_s2;
	qsst_pkg::cls_t    cls_s2;
	logic [31:0]       cm_s2 [3];
	logic [2:0]        cn_s2;
	logic [2:0]        cz_s2;
	logic [31:0]       pm_s2 [3];
	logic [2:0]        pn_s2;
	logic [2:0]        pz_s2;
	logic [31:0]       vm_s2 [3];
	logic [2:0]        vn_s2;
	logic [31:0]       psm_s2;
	logic              psn_s2;
	logic [31:0]       vsm_s2;
	logic              vsn_s2;
	logic signed [31:0] c0_s2, c1_s2, c3_s2;

	// Stage 3: products.
	logic              valid_s3;
	qsst_pkg::cls_t    cls_s3;
	logic [63:0]       sq_s3 [3];
	logic [63:0]       pc_s3 [3];
	logic [63:0]       cv_s3 [3];
	logic [63:0]       pv_s3 [3];
	logic [63:0]       gnum_s3 [3];
	logic [2:0]        pcn_s3, cvn_s3, pvn_s3;
	logic [63:0]       cp_s3;
	logic              cpn_s3;
	logic [31:0]       cm_s3 [3];
	logic              c1n_s3;
	qsst_pkg::vside_t  vside_s3;
	qsst_pkg::dside_t  dside_s3;
	logic signed [31:0] c0_s3, c1_s3, c3_s3;

	// Stage 4: scaled signed terms.
	logic              valid_s4;
	qsst_pkg::cls_t    cls_s4;
	logic signed [63:0] sqt_s4 [3];
	logic signed [63:0] pct_s4 [3];
	logic signed [63:0] cvt_s4 [3];
	logic signed [63:0] pvt_s4 [3];
	logic signed [31:0] c0_s4, c1_s4, c3_s4;

	// Stage 5: partial sums.
	logic              valid_s5;
	qsst_pkg::cls_t    cls_s5;
	logic signed [63:0] dpl_s5, gpl_s5, dq_s5, gq_s5;
	logic signed [31:0] c0_s5;

	// Stages 6 to 8: final value, gradient and decision.
	logic              valid_s6;
	qsst_pkg::cls_t    cls_s6;
	logic signed [63:0] d_s6, g_s6;
	logic              valid_s7;
	qsst_pkg::cls_t    cls_s7;
	logic signed [63:0] d_s7, g_s7;
	logic signed [63:0] cone_x, cone_y;
	qsst_pkg::early_t  early_d;
	qsst_pkg::early_t  early_s8;
	qsst_pkg::early_t  early_dly;

	// Stages 9 to 14 follow the divider pipeline.
	logic [63:0]       qd [3];
	logic [63:0]       qg [3];
	qsst_pkg::dside_t  dside_dly;
	qsst_pkg::vside_t  vside_dly;
	logic signed [63:0] dq_s9 [3];
	logic [63:0]       gqm_s9 [3];
	logic [2:0]        gneg_s9;
	logic              ell3_s9;
	logic signed [63:0] m_g [3];
	logic signed [63:0] d_s10, dq2_s10;
	logic              ell3_s10;
	logic signed [63:0] d_s11;
	logic              ell3_s11;
	logic signed [63:0] d_s12;
	logic              ell3_s12;
	logic signed [63:0] d_s13, g_s13, m2_s13;
	logic              ell3_s13;
	logic signed [63:0] d_s14, g_s14;
	logic              late_res;

	logic              done_q, inside_q, bad_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 31'd1;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			done_q   <= 1'b0;
			bad_q    <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			done_q   <= early_dly.valid;
			bad_q    <= early_dly.valid & early_dly.bad;
		end
	end

	always_ff @(posedge clk) begin
		type_s1 <= surf_type;
		c_s1[0] <= coef0;
		c_s1[1] <= coef1;
		c_s1[2] <= coef2;
		c_s1[3] <= coef3;
		p_s1[0] <= pos_x;
		p_s1[1] <= pos_y;
		p_s1[2] <= pos_z;
		v_s1[0] <= dir_x;
		v_s1[1] <= dir_y;
		v_s1[2] <= dir_z;
	end

	always_comb begin
		cls_d = '0;
		sel_d = 2'd0;
		case (qsst_pkg::surf_t'(type_s1))
			qsst_pkg::SURF_PLANEX: cls_d.axis = 1'b1;
			qsst_pkg::SURF_PLANEY: begin
				cls_d.axis = 1'b1;
				sel_d      = 2'd1;
			end
			qsst_pkg::SURF_PLANEZ: begin
				cls_d.axis = 1'b1;
				sel_d      = 2'd2;
			end
			qsst_pkg::SURF_PLANE:  cls_d.plane  = 1'b1;
			qsst_pkg::SURF_SPHERE: cls_d.sphere = 1'b1;
			qsst_pkg::SURF_ELL:    cls_d.ell3   = 1'b1;
			qsst_pkg::SURF_CYLZ:   cls_d.cyl    = 1'b1;
			qsst_pkg::SURF_ELLZ:   cls_d.ell2   = 1'b1;
			qsst_pkg::SURF_CONE:   cls_d.cone   = 1'b1;
			default:               cls_d.bad    = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		cls_s2 <= cls_d;
		for (int i = 0; i < 3; i++) begin
			cm_s2[i] <= qsst_pkg::mag32(c_s1[i]);
			cn_s2[i] <= c_s1[i][31];
			cz_s2[i] <= c_s1[i] == 32'sd0;
			pm_s2[i] <= qsst_pkg::mag32(p_s1[i]);
			pn_s2[i] <= p_s1[i][31];
			pz_s2[i] <= p_s1[i] == 32'sd0;
			vm_s2[i] <= qsst_pkg::mag32(v_s1[i]);
			vn_s2[i] <= v_s1[i][31];
		end
		psm_s2 <= qsst_pkg::mag32(p_s1[sel_d]);
		psn_s2 <= p_s1[sel_d][31];
		vsm_s2 <= qsst_pkg::mag32(v_s1[sel_d]);
		vsn_s2 <= v_s1[sel_d][31];
		c0_s2  <= c_s1[0];
		c1_s2  <= c_s1[1];
		c3_s2  <= c_s1[3];
	end

	always_ff @(posedge clk) begin
		cls_s3 <= cls_s2;
		for (int i = 0; i < 3; i++) begin
			sq_s3[i]   <= 64'(pm_s2[i]) * 64'(pm_s2[i]);
			pv_s3[i]   <= 64'(pm_s2[i]) * 64'(vm_s2[i]);
			pvn_s3[i]  <= pn_s2[i] ^ vn_s2[i];
			gnum_s3[i] <= 64'(pm_s2[i]) << FRAC_BITS;
			cm_s3[i]   <= cm_s2[i];
		end
		pc_s3[0]  <= 64'(cm_s2[0]) * 64'(psm_s2);
		pcn_s3[0] <= cn_s2[0] ^ psn_s2;
		cv_s3[0]  <= 64'(cm_s2[0]) * 64'(vsm_s2);
		cvn_s3[0] <= cn_s2[0] ^ vsn_s2;
		for (int i = 1; i < 3; i++) begin
			pc_s3[i]  <= 64'(cm_s2[i]) * 64'(pm_s2[i]);
			pcn_s3[i] <= cn_s2[i] ^ pn_s2[i];
			cv_s3[i]  <= 64'(cm_s2[i]) * 64'(vm_s2[i]);
			cvn_s3[i] <= cn_s2[i] ^ vn_s2[i];
		end
		cp_s3  <= 64'(cm_s2[1]) * 64'(pm_s2[2]);
		cpn_s3 <= cn_s2[1] ^ pn_s2[2];
		c1n_s3 <= cn_s2[1];
		vside_s3.vneg <= vn_s2;
		for (int i = 0; i < 3; i++) begin
			vside_s3.vm[i] <= vm_s2[i];
		end
		dside_s3.ell3 <= cls_s2.ell3;
		dside_s3.cneg <= cn_s2;
		dside_s3.cz   <= cz_s2;
		dside_s3.pz   <= pz_s2;
		dside_s3.pneg <= pn_s2;
		c0_s3 <= c0_s2;
		c1_s3 <= c1_s2;
		c3_s3 <= c3_s2;
	end

	// Cone axial terms: c1 * z^2 and (c1 * z) * dir_z.
	qsst_mulsh #(.FRAC_BITS(FRAC_BITS)) u_cone_x (
		.clk (clk),
		.a   (sq_s3[2] >> FRAC_BITS),
		.b   (cm_s3[1]),
		.neg (c1n_s3),
		.y   (cone_x)
	);

	qsst_mulsh #(.FRAC_BITS(FRAC_BITS)) u_cone_y (
		.clk (clk),
		.a   (cp_s3 >> FRAC_BITS),
		.b   (vside_s3.vm[2]),
		.neg (cpn_s3 ^ vside_s3.vneg[2]),
		.y   (cone_y)
	);

	always_ff @(posedge clk) begin
		cls_s4 <= cls_s3;
		for (int i = 0; i < 3; i++) begin
			sqt_s4[i] <= qsst_pkg::sgn64(1'b0, sq_s3[i] >> FRAC_BITS);
			pct_s4[i] <= qsst_pkg::sgn64(pcn_s3[i], pc_s3[i] >> FRAC_BITS);
			cvt_s4[i] <= qsst_pkg::sgn64(cvn_s3[i], cv_s3[i] >> FRAC_BITS);
			pvt_s4[i] <= qsst_pkg::sgn64(pvn_s3[i], pv_s3[i] >> FRAC_BITS);
		end
		c0_s4 <= c0_s3;
		c1_s4 <= c1_s3;
		c3_s4 <= c3_s3;
	end

	// These sums are bounded well below the saturation limit.
	always_ff @(posedge clk) begin
		cls_s5 <= cls_s4;
		c0_s5  <= c0_s4;
		if (cls_s4.axis) begin
			dpl_s5 <= pct_s4[0] + qsst_pkg::sext32(c1_s4);
			gpl_s5 <= cvt_s4[0];
		end else begin
			dpl_s5 <= pct_s4[0] + pct_s4[1] + pct_s4[2] + qsst_pkg::sext32(c3_s4);
			gpl_s5 <= cvt_s4[0] + cvt_s4[1] + cvt_s4[2];
		end
		dq_s5 <= sqt_s4[0] + sqt_s4[1] + (cls_s4.sphere ? sqt_s4[2] : 64'sd0);
		gq_s5 <= pvt_s4[0] + pvt_s4[1] + (cls_s4.sphere ? pvt_s4[2] : 64'sd0);
	end

	always_ff @(posedge clk) begin
		cls_s6 <= cls_s5;
		if (cls_s5.axis || cls_s5.plane) begin
			d_s6 <= dpl_s5;
			g_s6 <= gpl_s5;
		end else if (cls_s5.sphere || cls_s5.cyl) begin
			d_s6 <= dq_s5 - qsst_pkg::sext32(c0_s5);
			g_s6 <= gq_s5;
		end else begin
			d_s6 <= dq_s5;
			g_s6 <= gq_s5;
		end
	end

	always_ff @(posedge clk) begin
		cls_s7 <= cls_s6;
		if (cls_s6.cone) begin
			d_s7 <= qsst_pkg::sadd(d_s6, -cone_x);
			g_s7 <= qsst_pkg::sadd(g_s6, -cone_y);
		end else begin
			d_s7 <= d_s6;
			g_s7 <= g_s6;
		end
	end

	always_comb begin
		early_d.valid = valid_s7;
		early_d.bad   = cls_s7.bad;
		early_d.ell   = cls_s7.ell3 | cls_s7.ell2;
		case (qsst_pkg::band(d_s7, tol_q))
			qsst_pkg::BAND_OUT: early_d.res = 1'b0;
			qsst_pkg::BAND_IN:  early_d.res = 1'b1;
			default: begin
				if (cls_s7.axis || cls_s7.plane) begin
					early_d.res = !(g_s7 > 64'sd0);
				end else begin
					early_d.res = g_s7 < 64'sd0;
				end
			end
		endcase
		if (cls_s7.bad) begin
			early_d.res = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_s8 <= '0;
		end else begin
			early_s8 <= early_d;
		end
	end

	qsst_dly #(.W($bits(qsst_pkg::early_t)), .DEPTH(qsst_pkg::QW + 1)) u_early_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (early_s8),
		.dout   (early_dly)
	);

	// Ellipsoid path: quotients of squares and of scaled coordinates.
	for (genvar i = 0; i < 3; i++) begin : g_div
		qsst_div #(.NUM_W(qsst_pkg::QW), .DEN_W(qsst_pkg::CW)) u_div_d (
			.clk (clk),
			.num (sq_s3[i]),
			.den (cm_s3[i]),
			.quo (qd[i])
		);

		qsst_div #(.NUM_W(qsst_pkg::QW), .DEN_W(qsst_pkg::CW)) u_div_g (
			.clk (clk),
			.num (gnum_s3[i]),
			.den (cm_s3[i]),
			.quo (qg[i])
		);
	end

	qsst_dly #(.W($bits(qsst_pkg::dside_t)), .DEPTH(qsst_pkg::QW)) u_dside_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (dside_s3),
		.dout   (dside_dly)
	);

	qsst_dly #(.W($bits(qsst_pkg::vside_t)), .DEPTH(qsst_pkg::QW + 1)) u_vside_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (vside_s3),
		.dout   (vside_dly)
	);

	// A zero divisor saturates the quotient unless the numerator is zero too.
	always_ff @(posedge clk) begin
		ell3_s9 <= dside_dly.ell3;
		for (int i = 0; i < 3; i++) begin
			if (dside_dly.cz[i]) begin
				dq_s9[i]  <= qsst_pkg::sgn64(1'b0,
					dside_dly.pz[i] ? 64'd0 : 64'(qsst_pkg::QMAX));
				gqm_s9[i] <= dside_dly.pz[i] ? 64'd0 : 64'(qsst_pkg::QMAX);
			end else begin
				dq_s9[i]  <= qsst_pkg::sgn64(dside_dly.cneg[i],
					qd[i][63] ? 64'(qsst_pkg::QMAX) : qd[i]);
				gqm_s9[i] <= qg[i][63] ? 64'(qsst_pkg::QMAX) : qg[i];
			end
			gneg_s9[i] <= dside_dly.pneg[i] ^ dside_dly.cneg[i];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_emul
		qsst_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul (
			.clk (clk),
			.a   (gqm_s9[i]),
			.b   (vside_dly.vm[i]),
			.neg (gneg_s9[i] ^ vside_dly.vneg[i]),
			.y   (m_g[i])
		);
	end

	always_ff @(posedge clk) begin
		d_s10    <= qsst_pkg::sadd(dq_s9[0], dq_s9[1]);
		dq2_s10  <= dq_s9[2];
		ell3_s10 <= ell3_s9;
		d_s11    <= qsst_pkg::sadd(d_s10, ell3_s10 ? dq2_s10 : 64'sd0);
		ell3_s11 <= ell3_s10;
		d_s12    <= qsst_pkg::sadd(d_s11, -ONE_Q);
		ell3_s12 <= ell3_s11;
		d_s13    <= d_s12;
		g_s13    <= qsst_pkg::sadd(m_g[0], m_g[1]);
		m2_s13   <= m_g[2];
		ell3_s13 <= ell3_s12;
		d_s14    <= d_s13;
		g_s14    <= qsst_pkg::sadd(g_s13, ell3_s13 ? m2_s13 : 64'sd0);
	end

	always_comb begin
		case (qsst_pkg::band(d_s14, tol_q))
			qsst_pkg::BAND_OUT: late_res = 1'b0;
			qsst_pkg::BAND_IN:  late_res = 1'b1;
			default:            late_res = g_s14 < 64'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		inside_q <= early_dly.ell ? late_res : early_dly.res;
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign bad_type   = bad_q;

endmodule
